// ===== sv/ble_pkg.sv =====
// Package for bone_length_enforce: widths, status codes, controller types.
// No dependencies.
package ble_pkg;

  localparam int unsigned PosW    = 24;
  localparam int unsigned DiffW   = 25;
  localparam int unsigned LenW    = 23;
  localparam int unsigned MinW    = 16;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned PidxW   = 7;
  localparam int unsigned SumW    = 50;
  localparam int unsigned RadW    = 62;   // S << 12
  localparam int unsigned RootW   = 31;   // root of a RadW-bit radicand
  localparam int unsigned NumW    = 54;   // |d| * len * 64
  localparam int unsigned ExtraBits = 6;

  typedef enum logic [1:0] {
    StRescaled = 2'd0,
    StNoParent = 2'd1,
    StShort    = 2'd2,
    StBadOrder = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CtlIdle,
    CtlRead,
    CtlDiff,
    CtlSq,
    CtlSum,
    CtlSqrt,
    CtlDivInit,
    CtlDiv,
    CtlAdd,
    CtlWrite,
    CtlOut
  } ctl_state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic       load;       // capture input item
    logic       rd;         // read parent store entry
    logic       diff;       // compute differences
    logic       sq;         // square one axis per step
    logic       sum;        // sum squares, classify
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;   // set up division for current axis
    logic       div_step;
    logic       add;        // add offset for current axis
    logic       wr;         // write store, present result
    logic [1:0] axis;
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic    special;      // no rescale needed
    logic    sqrt_done;
    logic    div_done;
  } sts_t;

endpackage

// ===== sv/ble_if.sv =====
// Valid/ready channel interfaces for bone_length_enforce.
// Depends on ble_pkg.
interface ble_in_if;
  logic                         valid;
  logic                         ready;
  logic [ble_pkg::IdxW-1:0]     joint_index;
  logic signed [ble_pkg::PidxW-1:0] parent_index;
  logic [ble_pkg::LenW-1:0]     bone_length;
  logic signed [ble_pkg::PosW-1:0] pos_x;
  logic signed [ble_pkg::PosW-1:0] pos_y;
  logic signed [ble_pkg::PosW-1:0] pos_z;
  modport source (output valid, joint_index, parent_index, bone_length, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, joint_index, parent_index, bone_length, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface ble_out_if;
  logic                         valid;
  logic                         ready;
  logic [ble_pkg::IdxW-1:0]     out_index;
  logic signed [ble_pkg::PosW-1:0] out_x;
  logic signed [ble_pkg::PosW-1:0] out_y;
  logic signed [ble_pkg::PosW-1:0] out_z;
  logic [1:0]                   status;
  modport source (output valid, out_index, out_x, out_y, out_z, status, input ready);
  modport sink (input valid, out_index, out_x, out_y, out_z, status, output ready);
endinterface

// ===== sv/bone_length_enforce.sv =====
// bone_length_enforce: one joint at a time. Pass-through joints skip the root
// steps and the divider; for a rescaled joint, 31 root steps plus three axis
// divisions (54 steps each on the shared restoring divider) dominate.
// The next joint is taken in the cycle the result can first transfer, and
// not before; output back-pressure adds stalls.
// Reset clears the controller, the output valid and min_length; the position
// store is not cleared.
module bone_length_enforce #(
  parameter int unsigned MAX_JOINTS = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ble_pkg::MinW-1:0] cfg_wdata_i,
  ble_in_if.sink                   in_if,
  ble_out_if.source                out_if
);
  // position units are raw LSBs; fraction width only documents the format
  localparam int unsigned FracUnused = FRAC_BITS;

  logic [ble_pkg::MinW-1:0] min_len_q;
  ble_pkg::cmd_t cmd;
  ble_pkg::sts_t sts;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) min_len_q <= '0;
    else if (cfg_we_i) min_len_q <= cfg_wdata_i;
  end

  ble_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ble_dp #(.MaxJoints(MAX_JOINTS + FracUnused * 0)) u_dp (
    .clk_i          (clk_i),
    .min_length_i   (min_len_q),
    .joint_index_i  (in_if.joint_index),
    .parent_index_i (in_if.parent_index),
    .bone_length_i  (in_if.bone_length),
    .pos_x_i        (in_if.pos_x),
    .pos_y_i        (in_if.pos_y),
    .pos_z_i        (in_if.pos_z),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_index_o    (out_if.out_index),
    .out_x_o        (out_if.out_x),
    .out_y_o        (out_if.out_y),
    .out_z_o        (out_if.out_z),
    .status_o       (out_if.status)
  );

endmodule

// ===== sv/ble_ctrl.sv =====
// Controller FSM for bone_length_enforce: sequences the datapath per joint.
// Depends on ble_pkg.
module ble_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ble_pkg::cmd_t   cmd_o,
  input  ble_pkg::sts_t   sts_i
);

  ble_pkg::ctl_state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ble_pkg::CtlIdle;
      axis_q   <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      axis_q   <= axis_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    ovalid_d   = ovalid_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      ble_pkg::CtlIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ble_pkg::CtlRead;
        end
      end
      ble_pkg::CtlRead: begin
        cmd_o.rd = 1'b1;
        state_d  = ble_pkg::CtlDiff;
      end
      ble_pkg::CtlDiff: begin
        cmd_o.diff = 1'b1;
        axis_d     = 2'd0;
        state_d    = ble_pkg::CtlSq;
      end
      ble_pkg::CtlSq: begin
        cmd_o.sq = 1'b1;
        axis_d   = axis_q + 2'd1;
        if (axis_q == 2'd2) state_d = ble_pkg::CtlSum;
      end
      ble_pkg::CtlSum: begin
        cmd_o.sum = 1'b1;
        state_d   = ble_pkg::CtlSqrt;
      end
      ble_pkg::CtlSqrt: begin
        if (sts_i.special) begin
          state_d = ble_pkg::CtlWrite;
        end else begin
          cmd_o.sqrt_step = 1'b1;
          if (sts_i.sqrt_done) begin
            axis_d  = 2'd0;
            state_d = ble_pkg::CtlDivInit;
          end
        end
      end
      ble_pkg::CtlDivInit: begin
        cmd_o.div_init = 1'b1;
        state_d        = ble_pkg::CtlDiv;
      end
      ble_pkg::CtlDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ble_pkg::CtlAdd;
      end
      ble_pkg::CtlAdd: begin
        cmd_o.add = 1'b1;
        axis_d    = axis_q + 2'd1;
        state_d   = (axis_q == 2'd2) ? ble_pkg::CtlWrite : ble_pkg::CtlDivInit;
      end
      ble_pkg::CtlWrite: begin
        // wait for the output register to drain
        if (!ovalid_q || out_ready_i) begin
          cmd_o.wr = 1'b1;
          ovalid_d = 1'b1;
          state_d  = ble_pkg::CtlIdle;
        end
      end
      default: state_d = ble_pkg::CtlIdle;
    endcase
    cmd_o.sqrt_init = cmd_o.sum;
  end

endmodule

// ===== sv/ble_dp.sv =====
// Datapath for bone_length_enforce: position stores, squarer, root, divider.
// Depends on ble_pkg.
module ble_dp #(
  parameter int unsigned MaxJoints = 64
) (
  input  logic                              clk_i,
  input  logic [ble_pkg::MinW-1:0]          min_length_i,
  input  logic [ble_pkg::IdxW-1:0]          joint_index_i,
  input  logic signed [ble_pkg::PidxW-1:0]  parent_index_i,
  input  logic [ble_pkg::LenW-1:0]          bone_length_i,
  input  logic signed [ble_pkg::PosW-1:0]   pos_x_i,
  input  logic signed [ble_pkg::PosW-1:0]   pos_y_i,
  input  logic signed [ble_pkg::PosW-1:0]   pos_z_i,
  input  ble_pkg::cmd_t                     cmd_i,
  output ble_pkg::sts_t                     sts_o,
  output logic [ble_pkg::IdxW-1:0]          out_index_o,
  output logic signed [ble_pkg::PosW-1:0]   out_x_o,
  output logic signed [ble_pkg::PosW-1:0]   out_y_o,
  output logic signed [ble_pkg::PosW-1:0]   out_z_o,
  output logic [1:0]                        status_o
);
  localparam int unsigned AW = (MaxJoints > 1) ? $clog2(MaxJoints) : 1;
  localparam int unsigned PW = ble_pkg::PosW;
  localparam int unsigned DW = ble_pkg::DiffW;

  // Position memory, one entry per joint: {x, y, z}
  logic [3*PW-1:0] mem [MaxJoints];
  logic [3*PW-1:0] rd_q;

  // Captured item
  logic [ble_pkg::IdxW-1:0]    ji_q;
  logic signed [ble_pkg::PidxW-1:0] pi_q;
  logic [ble_pkg::LenW-1:0]    len_q;
  logic signed [PW-1:0]        p_q [3];
  logic signed [PW-1:0]        o_q [3];
  logic signed [DW-1:0]        d_q [3];
  logic [ble_pkg::SumW-1:0]    s_q;
  logic [ble_pkg::SumW-1:0]    sq_q;
  logic [1:0]                  st_q;
  logic                        special_q;

  logic [AW-1:0] slot_w, slot_r;
  assign slot_w = AW'(ji_q);
  assign slot_r = AW'(pi_q[ble_pkg::PidxW-2:0]);

  // Square root: remainder/root, two radicand bits per step
  logic [ble_pkg::RadW-1:0]  rad_q;
  logic [ble_pkg::RootW+1:0] rem_q;
  logic [ble_pkg::RootW-1:0] root_q;
  logic [4:0]                sq_cnt_q;
  logic [ble_pkg::RootW+1:0] trial;
  logic [ble_pkg::RootW+1:0] rem_sh;
  assign rem_sh = {rem_q[ble_pkg::RootW-1:0], rad_q[ble_pkg::RadW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  // Restoring divider, one quotient bit per step
  localparam int unsigned NW = ble_pkg::NumW;
  logic [NW-1:0]             num_q;
  logic [ble_pkg::RootW:0]   drem_q;
  logic [5:0]                div_cnt_q;
  logic [ble_pkg::RootW:0]   drem_sh;
  logic [ble_pkg::RootW:0]   dtry;
  assign drem_sh = {drem_q[ble_pkg::RootW-1:0], num_q[NW-1]};
  assign dtry    = drem_sh - {1'b0, root_q};

  // Multiplier operands: magnitude of the current axis difference, min_length squared
  logic signed [DW-1:0] sqd;
  logic [DW-1:0]        mag;
  logic [ble_pkg::SumW-1:0] m2;
  assign sqd = d_q[cmd_i.axis];
  assign mag = sqd[DW-1] ? DW'(-sqd) : DW'(sqd);
  assign m2  = ble_pkg::SumW'(min_length_i) * ble_pkg::SumW'(min_length_i);

  // Final add with saturation
  logic signed [PW+NW:0] sum_full;
  logic [NW-1:0] qv;
  assign qv = num_q;
  assign sum_full = $signed({{(NW+1){rd_q[(2-cmd_i.axis)*PW+PW-1]}},
                             rd_q[(2-cmd_i.axis)*PW +: PW]})
                  + (d_q[cmd_i.axis][DW-1] ? -$signed({1'b0, {PW{1'b0}}, qv})
                                           : $signed({1'b0, {PW{1'b0}}, qv}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem[slot_w] <= {o_q[0], o_q[1], o_q[2]};
    if (cmd_i.rd) rd_q <= mem[slot_r];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ji_q   <= joint_index_i;
      pi_q   <= parent_index_i;
      len_q  <= bone_length_i;
      p_q[0] <= pos_x_i;
      p_q[1] <= pos_y_i;
      p_q[2] <= pos_z_i;
      o_q[0] <= pos_x_i;
      o_q[1] <= pos_y_i;
      o_q[2] <= pos_z_i;
      s_q    <= '0;
    end
    if (cmd_i.diff) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= DW'(p_q[i]) - DW'($signed(rd_q[(2-i)*PW +: PW]));
      end
    end
    if (cmd_i.sq) begin
      sq_q <= ble_pkg::SumW'(mag) * ble_pkg::SumW'(mag);
      if (cmd_i.axis != 2'd0) s_q <= s_q + sq_q;
    end
    // classify
    if (cmd_i.sum) begin
      special_q <= 1'b1;
      if (ji_q == '0 || pi_q < 0) begin
        st_q <= ble_pkg::StNoParent;
      end else if ($unsigned(pi_q) >= {1'b0, ji_q}) begin
        st_q <= ble_pkg::StBadOrder;
      end else if ((s_q + sq_q) <= m2) begin
        st_q <= ble_pkg::StShort;
      end else begin
        st_q      <= ble_pkg::StRescaled;
        special_q <= 1'b0;
      end
    end
    // start root on S << 12
    if (cmd_i.sqrt_init) begin
      rad_q    <= {s_q + sq_q, 12'd0};
      rem_q    <= '0;
      root_q   <= '0;
      sq_cnt_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_q    <= {rad_q[ble_pkg::RadW-3:0], 2'b00};
      sq_cnt_q <= sq_cnt_q + 5'd1;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ble_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ble_pkg::RootW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_init) begin
      // |d|*len*64 + n/2
      num_q     <= NW'({NW'(mag) * NW'(len_q), 6'd0}) + NW'(root_q >> 1);
      drem_q    <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 6'd1;
      if (!dtry[ble_pkg::RootW]) begin
        drem_q <= dtry;
        num_q  <= {num_q[NW-2:0], 1'b1};
      end else begin
        drem_q <= drem_sh;
        num_q  <= {num_q[NW-2:0], 1'b0};
      end
    end
    if (cmd_i.add) begin
      if (sum_full > $signed((PW+NW+1)'(ble_pkg::PosW'(24'h7FFFFF))))
        o_q[cmd_i.axis] <= 24'sh7FFFFF;
      else if (sum_full < -$signed((PW+NW+1)'(25'h0800000)))
        o_q[cmd_i.axis] <= -24'sh800000;
      else
        o_q[cmd_i.axis] <= sum_full[PW-1:0];
    end
    if (cmd_i.wr) begin
      out_index_o <= ji_q;
      out_x_o     <= o_q[0];
      out_y_o     <= o_q[1];
      out_z_o     <= o_q[2];
      status_o    <= st_q;
    end
  end

  assign sts_o.special   = special_q;
  assign sts_o.sqrt_done = (sq_cnt_q == 5'd30);
  assign sts_o.div_done  = (div_cnt_q == 6'(NW - 1));

endmodule
